### sv/emm_pkg.sv
// Package: shared constants and codes for the expanded memory page manager.
`timescale 1ns / 1ps
`default_nettype none
package emm_pkg;

  localparam int TOTAL_PAGES_DEF = 1024;
  localparam int MAX_HANDLES_DEF = 16;
  localparam int FRAME_SLOTS_DEF = 4;

  localparam logic [15:0] SEG_RESET  = 16'hD000;
  localparam logic [15:0] UNMAP_PAGE = 16'hFFFF;

  localparam int IN_W  = 64;
  localparam int OUT_W = 48;

  typedef enum logic [7:0] {
    FN_STATUS  = 8'h40,
    FN_SEGMENT = 8'h41,
    FN_AVAIL   = 8'h42,
    FN_ALLOC   = 8'h43,
    FN_MAP     = 8'h44,
    FN_FREE    = 8'h45
  } emm_fn_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_HANDLE  = 3'd1,
    ST_ZERO_PAGES  = 3'd2,
    ST_NO_HANDLES  = 3'd3,
    ST_FEW_PAGES   = 3'd4,
    ST_BAD_PHYS    = 3'd5,
    ST_BAD_LOGICAL = 3'd6,
    ST_UNKNOWN     = 3'd7
  } emm_status_t;

endpackage
`default_nettype wire

### sv/expanded_memory_page_manager.sv
// Top level: expanded memory page manager with frame segment register.
//
// in_* carries one request word per handshake; out_* returns exactly one result
// word per request, in order. cfg_we/cfg_wdata set the frame segment reported
// by function 41h (reset D000h); write it only while the block is idle.
// Status, segment, counts and argument errors go from acceptance through the
// decode and response states to out_tvalid. Allocate first searches for a free
// handle; allocate, map and free then scan the page-owner RAM one entry per
// cycle, bound by its single read port.
// One request is worked at a time; the next is accepted as soon as the
// previous result sits in the output register, even while out_tready is low.
// A stalled receiver holds the result; a further result waits until it is taken.
// After reset the page-owner RAM is cleared, one entry per cycle, with in_tready
// low; cfg writes are still taken.
`timescale 1ns / 1ps
`default_nettype none
module expanded_memory_page_manager #(
  parameter int TOTAL_PAGES = emm_pkg::TOTAL_PAGES_DEF,
  parameter int MAX_HANDLES = emm_pkg::MAX_HANDLES_DEF,
  parameter int FRAME_SLOTS = emm_pkg::FRAME_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // action[7:0], num_pages[23:8], handle[39:24], physical_page[47:40],
  // logical_page[63:48]
  input  wire logic [63:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[2:0], word_b[18:3], word_d[34:19], frame_page[44:35],
  // frame_valid[45], zero[47:46]
  output logic      [47:0] out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import emm_pkg::*;

  logic [15:0] frame_segment_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_segment_r <= SEG_RESET;
    end else if (cfg_we) begin
      frame_segment_r <= cfg_wdata;
    end
  end

  emm_ctrl #(
    .TOTAL_PAGES (TOTAL_PAGES),
    .MAX_HANDLES (MAX_HANDLES),
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .in_data       (in_tdata),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_data      (out_tdata),
    .frame_segment (frame_segment_r)
  );

endmodule
`default_nettype wire

### sv/emm_sram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module emm_sram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/emm_ctrl.sv
// Request sequencer: decode, handle search, page-owner scans and result register.
`timescale 1ns / 1ps
`default_nettype none
module emm_ctrl #(
  parameter int TOTAL_PAGES = 1024,
  parameter int MAX_HANDLES = 16,
  parameter int FRAME_SLOTS = 4
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [emm_pkg::IN_W-1:0]  in_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic      [emm_pkg::OUT_W-1:0] out_data,
  input  wire logic [15:0]             frame_segment
);
  import emm_pkg::*;

  localparam int PW = $clog2(TOTAL_PAGES);
  localparam int CW = $clog2(TOTAL_PAGES + 1);
  localparam int HW = $clog2(MAX_HANDLES);
  localparam int OW = $clog2(MAX_HANDLES + 1);
  localparam int SW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam logic [PW-1:0] LAST_PAGE   = PW'(TOTAL_PAGES - 1);
  localparam logic [HW-1:0] LAST_HANDLE = HW'(MAX_HANDLES - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DEC, S_HSCAN, S_CNT, S_SCAN, S_RESP
  } state_t;

  state_t             state_r;
  logic [7:0]         act_r;
  logic [15:0]        npg_r, hdl_r, lgc_r;
  logic [7:0]         phys_r;
  emm_status_t        st_r;
  logic [15:0]        wb_r, wd_r;
  logic [HW-1:0]      h_r;
  logic [MAX_HANDLES-1:0] in_use_r;
  logic [CW-1:0]      free_cnt_r, cnt_r, run_r;
  logic [PW-1:0]      addr_r, ev_addr_r;
  logic               issue_done_r, ev_vld_r;
  logic [PW-1:0]      slot_page_r [FRAME_SLOTS];
  logic [FRAME_SLOTS-1:0] slot_vld_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic               in_fire;
  logic               hdl_ok;
  logic [OW-1:0]      own_id, own_rd, own_wdata;
  logic               own_we;
  logic [PW-1:0]      own_waddr;
  logic [CW-1:0]      cnt_rd;
  logic               cnt_we;
  logic               alloc_wr, alloc_last;
  logic [SW-1:0]      slot;
  logic [9:0]         fp;
  logic               fv;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot      = phys_r[SW-1:0];

  assign hdl_ok = (hdl_r < 16'(MAX_HANDLES)) ? in_use_r[hdl_r[HW-1:0]] : 1'b0;
  assign own_id = (act_r == FN_ALLOC) ? (OW'(h_r) + OW'(1))
                                      : (OW'(hdl_r[HW-1:0]) + OW'(1));

  // alloc takes a free page while fewer than the requested count are claimed
  assign alloc_wr   = (state_r == S_SCAN) && ev_vld_r && (act_r == FN_ALLOC) &&
                      (own_rd == '0) && (run_r < npg_r[CW-1:0]);
  assign alloc_last = alloc_wr && ((run_r + CW'(1)) == npg_r[CW-1:0]);
  assign cnt_we     = alloc_last;

  always_comb begin
    own_we    = 1'b0;
    own_waddr = ev_addr_r;
    own_wdata = '0;
    if (state_r == S_CLR) begin
      own_we    = 1'b1;
      own_waddr = addr_r;
    end else if (alloc_wr) begin
      own_we    = 1'b1;
      own_wdata = own_id;
    end else if ((state_r == S_SCAN) && ev_vld_r && (act_r == FN_FREE) &&
                 (own_rd == own_id)) begin
      own_we = 1'b1;
    end
  end

  emm_sram #(.DEPTH(TOTAL_PAGES), .WIDTH(OW)) u_owner (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (addr_r),
    .rdata (own_rd)
  );

  emm_sram #(.DEPTH(MAX_HANDLES), .WIDTH(CW)) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (h_r),
    .wdata (npg_r[CW-1:0]),
    .raddr (hdl_r[HW-1:0]),
    .rdata (cnt_rd)
  );

  always_comb begin
    fp = '0;
    fv = 1'b0;
    if ((act_r == FN_MAP) && (phys_r < 8'(FRAME_SLOTS)) && slot_vld_r[slot]) begin
      fp = 10'(slot_page_r[slot]);
      fv = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      addr_r       <= '0;
      issue_done_r <= 1'b0;
      ev_vld_r     <= 1'b0;
      in_use_r     <= '0;
      slot_vld_r   <= '0;
      free_cnt_r   <= CW'(TOTAL_PAGES);
      out_valid_r  <= 1'b0;
    end else begin
      // the output register reloads in the cycle it is emptied
      if ((state_r == S_RESP) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          addr_r <= addr_r + PW'(1);
          if (addr_r == LAST_PAGE) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            act_r   <= in_data[7:0];
            npg_r   <= in_data[23:8];
            hdl_r   <= in_data[39:24];
            phys_r  <= in_data[47:40];
            lgc_r   <= in_data[63:48];
            st_r    <= ST_OK;
            wb_r    <= '0;
            wd_r    <= '0;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          addr_r       <= '0;
          issue_done_r <= 1'b0;
          ev_vld_r     <= 1'b0;
          run_r        <= '0;
          h_r          <= '0;
          state_r      <= S_RESP;
          unique case (act_r)
            FN_STATUS: ;
            FN_SEGMENT: wb_r <= frame_segment;
            FN_AVAIL: begin
              wb_r <= 16'(free_cnt_r);
              wd_r <= 16'(TOTAL_PAGES);
            end
            FN_ALLOC: begin
              if (npg_r == '0) st_r <= ST_ZERO_PAGES;
              else state_r <= S_HSCAN;
            end
            FN_MAP: begin
              if (phys_r >= 8'(FRAME_SLOTS)) begin
                st_r <= ST_BAD_PHYS;
              end else if (lgc_r == UNMAP_PAGE) begin
                slot_vld_r[slot]  <= 1'b0;
                slot_page_r[slot] <= '0;
              end else if (!hdl_ok) begin
                st_r <= ST_BAD_HANDLE;
              end else begin
                state_r <= S_CNT;
              end
            end
            FN_FREE: begin
              if (!hdl_ok) st_r <= ST_BAD_HANDLE;
              else state_r <= S_CNT;
            end
            default: st_r <= ST_UNKNOWN;
          endcase
        end
        S_HSCAN: begin
          if (!in_use_r[h_r]) begin
            if (npg_r > 16'(free_cnt_r)) begin
              st_r    <= ST_FEW_PAGES;
              state_r <= S_RESP;
            end else begin
              state_r <= S_SCAN;
            end
          end else if (h_r == LAST_HANDLE) begin
            st_r    <= ST_NO_HANDLES;
            state_r <= S_RESP;
          end else begin
            h_r <= h_r + HW'(1);
          end
        end
        S_CNT: begin
          cnt_r <= cnt_rd;
          if ((act_r == FN_MAP) && (lgc_r >= 16'(cnt_rd))) begin
            st_r    <= ST_BAD_LOGICAL;
            state_r <= S_RESP;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one read issued per cycle, evaluated in the next cycle
          if (!issue_done_r) begin
            addr_r <= addr_r + PW'(1);
            if (addr_r == LAST_PAGE) issue_done_r <= 1'b1;
          end
          ev_vld_r  <= !issue_done_r;
          ev_addr_r <= addr_r;
          if (ev_vld_r) begin
            if (act_r == FN_ALLOC) begin
              if (alloc_wr) run_r <= run_r + CW'(1);
              if (alloc_last) begin
                in_use_r[h_r] <= 1'b1;
                free_cnt_r    <= free_cnt_r - npg_r[CW-1:0];
                wd_r          <= 16'(h_r);
                state_r       <= S_RESP;
              end else if (ev_addr_r == LAST_PAGE) begin
                st_r    <= ST_FEW_PAGES;
                state_r <= S_RESP;
              end
            end else if (act_r == FN_MAP) begin
              if ((own_rd == own_id) && (run_r == lgc_r[CW-1:0])) begin
                slot_page_r[slot] <= ev_addr_r;
                slot_vld_r[slot]  <= 1'b1;
                state_r           <= S_RESP;
              end else begin
                if (own_rd == own_id) run_r <= run_r + CW'(1);
                if (ev_addr_r == LAST_PAGE) begin
                  st_r    <= ST_BAD_LOGICAL;
                  state_r <= S_RESP;
                end
              end
            end else if (ev_addr_r == LAST_PAGE) begin
              free_cnt_r                <= free_cnt_r + cnt_r;
              in_use_r[hdl_r[HW-1:0]]   <= 1'b0;
              state_r                   <= S_RESP;
            end
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_data_r  <= {2'b00, fv, fp, wd_r, wb_r, st_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CW'(TOTAL_PAGES))
    else $error("free page count above total");

  a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_DEC))
    else $error("accepted word not decoded");

  a_claim_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(in_use_r) > $past($countones(in_use_r))) |-> $past(act_r == FN_ALLOC))
    else $error("handle claimed outside allocate");

  a_free_scan: assert property (@(posedge clk) disable iff (!rst_n)
    own_we |-> ((state_r == S_CLR) || (state_r == S_SCAN)))
    else $error("owner write outside scan");

endmodule
`default_nettype wire
